// ----- hdl/moving_average_filter_macros.svh -----
// Assertion macros used by the checker of the moving average filter.
// Depends on nothing; included by the checker module.
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/maf_pkg.sv -----
// Shared types and constants of the moving average filter.
// No dependencies; used by the interfaces and all modules but maf_ram.
`timescale 1ns / 1ps

package maf_pkg;

	localparam int DATA_W = 32;
	localparam int TS_W   = 32;
	localparam int CFG_W  = 11;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic        [TS_W-1:0]   ts_t;
	typedef logic        [CFG_W-1:0]  cfg_t;

	localparam cfg_t WINDOW_LEN_RESET = 11'd4;

endpackage

// ----- hdl/maf_if.sv -----
// Valid/ready channel interfaces for the input, result and configuration beats.
// Depends on maf_pkg.
`timescale 1ns / 1ps

interface maf_in_if;
	logic             valid;
	logic             ready;
	maf_pkg::sample_t sample_value;
	maf_pkg::ts_t     time_stamp;
	modport source(output valid, output sample_value, output time_stamp, input ready);
	modport sink(input valid, input sample_value, input time_stamp, output ready);
endinterface

interface maf_out_if;
	logic             valid;
	logic             ready;
	maf_pkg::sample_t average_value;
	maf_pkg::ts_t     time_stamp_out;
	modport source(output valid, output average_value, output time_stamp_out, input ready);
	modport sink(input valid, input average_value, input time_stamp_out, output ready);
endinterface

interface maf_cfg_if;
	logic          valid;
	logic          ready;
	maf_pkg::cfg_t window_len;
	modport source(output valid, output window_len, input ready);
	modport sink(input valid, input window_len, output ready);
endinterface

// ----- hdl/maf_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module maf_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ----- hdl/maf_div.sv -----
// Radix-2 restoring divider: signed dividend by unsigned divisor, truncated toward zero.
// Depends on maf_pkg.
`timescale 1ns / 1ps

module maf_div #(
	parameter int SUM_W = 42,
	parameter int LEN_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic        [LEN_W-1:0] divisor,
	output logic                    done,
	output maf_pkg::sample_t        quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quo_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             done_q;
	logic [LEN_W:0]   trial;
	logic             fits;
	logic [SUM_W-1:0] magnitude;

	assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign fits      = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(SUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= magnitude;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	// The mean always fits the sample width, so only the low bits are negated.
	assign quotient = neg_q ? maf_pkg::sample_t'(-quo_q[maf_pkg::DATA_W-1:0])
	                        : maf_pkg::sample_t'(quo_q[maf_pkg::DATA_W-1:0]);

endmodule

// ----- hdl/moving_average_filter.sv -----
// Moving average filter: one result beat per input beat, the truncated mean of the window.
// A result beat is offered once the window sum has been updated and divided by the window length.
// A new input beat is taken only once the last one has moved its result into the output register.
// Reset (arst_n low, asynchronous) sets the window length to 4 and empties the window.
// The sample store needs no clearing pass: a fill count marks the entries written so far.
// Depends on maf_pkg, maf_if, maf_ram and maf_div.
`timescale 1ns / 1ps

module moving_average_filter #(
	parameter int MAX_WINDOW = 1024
) (
	input logic       clk,
	input logic       arst_n,
	maf_cfg_if.sink   cfg_ch,
	maf_in_if.sink    in_ch,
	maf_out_if.source out_ch
);

	// Store address, window length, the width of an exact window sum and the comparison width.
	localparam int ADDR_W = $clog2(MAX_WINDOW);
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = maf_pkg::DATA_W + ADDR_W;
	localparam int CMP_W  = (LEN_W > maf_pkg::CFG_W) ? LEN_W : maf_pkg::CFG_W;

	// The sequencer walks one beat through read, subtract, add, divide and push.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_SUB  = 7'b0000100,
		ST_ADD  = 7'b0001000,
		ST_DIVS = 7'b0010000,
		ST_DIVW = 7'b0100000,
		ST_PUSH = 7'b1000000
	} state_t;

	state_t                  state_q;
	maf_pkg::cfg_t           window_len_q;
	logic [ADDR_W-1:0]       pos_q;
	logic [LEN_W-1:0]        fill_q;
	logic signed [SUM_W-1:0] sum_q;
	maf_pkg::sample_t        sample_q;
	maf_pkg::ts_t            ts_q;
	logic                    out_valid_q;
	maf_pkg::sample_t        avg_q;
	maf_pkg::ts_t            ts_out_q;

	logic [CMP_W-1:0]        cfg_ext;
	logic [LEN_W-1:0]        len;
	logic [ADDR_W-1:0]       cur_pos;
	logic [LEN_W-1:0]        nxt_pos;
	logic                    entry_live;
	logic                    ram_en;
	logic                    ram_we;
	maf_pkg::sample_t        ram_rdata;
	maf_pkg::sample_t        old_sample;
	logic                    div_start;
	logic                    div_done;
	maf_pkg::sample_t        div_quo;
	logic                    in_fire;
	logic                    out_fire;
	logic                    cfg_fire;
	logic                    push_fire;

	// A length of zero acts as one; lengths beyond the store saturate to its depth.
	assign cfg_ext = CMP_W'(window_len_q);
	always_comb begin
		if (cfg_ext == '0) begin
			len = LEN_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(cfg_ext);
		end
	end

	// The write position wraps at the window length.
	assign cur_pos = (LEN_W'(pos_q) >= len) ? '0 : pos_q;
	assign nxt_pos = LEN_W'(cur_pos) + LEN_W'(1);

	// Entries are written in order from zero after every restart, so an entry below
	// the fill count holds a sample and every other entry still reads as zero.
	assign entry_live = LEN_W'(cur_pos) < fill_q;
	assign old_sample = entry_live ? ram_rdata : '0;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

	// A finished result moves into the output register once that register is free or
	// is being emptied in the same cycle.
	assign push_fire = (state_q == ST_PUSH) && (!out_valid_q || out_ch.ready);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = (state_q == ST_IDLE);

	assign ram_en    = (state_q == ST_READ) || (state_q == ST_SUB);
	assign ram_we    = (state_q == ST_SUB);
	assign div_start = (state_q == ST_DIVS);

	maf_ram #(
		.WIDTH (maf_pkg::DATA_W),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (cur_pos),
		.wdata (sample_q),
		.rdata (ram_rdata)
	);

	maf_div #(
		.SUM_W (SUM_W),
		.LEN_W (LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (len),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer and window state. A configuration write restarts the window; the
	// configuration channel is ready only while the sequencer is idle, so no beat is
	// ever part way through its update when the window is cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_len_q <= maf_pkg::WINDOW_LEN_RESET;
			pos_q        <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				window_len_q <= cfg_ch.window_len;
				pos_q        <= '0;
				fill_q       <= '0;
				sum_q        <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					// Drop the oldest sample; the store takes the new one this cycle.
					sum_q <= sum_q - SUM_W'(old_sample);
					if (LEN_W'(cur_pos) == fill_q) begin
						fill_q <= fill_q + LEN_W'(1);
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q   <= sum_q + SUM_W'(sample_q);
					pos_q   <= (nxt_pos >= len) ? '0 : ADDR_W'(nxt_pos);
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					// The output register frees the input side while a result waits.
					if (push_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= in_ch.sample_value;
			ts_q     <= in_ch.time_stamp;
		end
		if (push_fire) begin
			avg_q    <= div_quo;
			ts_out_q <= ts_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.average_value  = avg_q;
	assign out_ch.time_stamp_out = ts_out_q;

endmodule

// ----- hdl/maf_checker.sv -----
// Port-level assertions of the moving average filter and their bind to the top level.
// Depends on maf_pkg and moving_average_filter_macros.svh.
`timescale 1ns / 1ps
`include "moving_average_filter_macros.svh"

module maf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input maf_pkg::sample_t average_value,
	input maf_pkg::ts_t     time_stamp_out
);

	// The block works on one beat at a time and stays busy through the update.
	`MAF_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while busy")
	`MAF_ASSERT_IMP(a_busy_during_update, clk, arst_n, in_valid && in_ready, ##3 !in_ready, "input taken during update")
	`MAF_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(average_value) && $stable(time_stamp_out), "stalled result changed")

endmodule

bind moving_average_filter maf_checker u_maf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.average_value  (out_ch.average_value),
	.time_stamp_out (out_ch.time_stamp_out)
);

// ----- bench/tb_moving_average_filter.sv -----
// Self-checking testbench of the moving average filter: directed window cases, then random beats.
// Depends on maf_pkg, the channel interfaces in maf_if and the moving_average_filter top level.
`timescale 1ns / 1ps

module tb_moving_average_filter;

	typedef maf_pkg::sample_t sample_t;
	typedef maf_pkg::ts_t     ts_t;
	typedef maf_pkg::cfg_t    cfg_t;

	localparam int          CLK_PERIOD    = 10;
	localparam int          MAX_WINDOW    = 1024;
	localparam int          RESET_CYCLES  = 9;
	localparam int          SETTLE_CYCLES = 60;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          REPORT_LIMIT  = 10;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;

	localparam sample_t SAMPLE_MAX = sample_t'(32'h7FFF_FFFF);
	localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);

	typedef struct packed {
		sample_t sample_value;
		ts_t     time_stamp;
	} input_beat_t;

	typedef struct packed {
		sample_t average_value;
		ts_t     time_stamp_out;
	} average_beat_t;

	// How the samples of a sequence are drawn: anything, or mostly near one extreme so
	// that the window sum is pushed towards its largest magnitude.
	typedef enum int {MIX_ANY, MIX_HIGH, MIX_LOW} sample_mix_t;

	logic clk = 1'b0;
	logic arst_n;

	maf_cfg_if cfg_ch();
	maf_in_if  in_ch();
	maf_out_if out_ch();

	moving_average_filter #(.MAX_WINDOW(MAX_WINDOW)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the filter state: the ring of samples, the next slot to overwrite,
	// the exact window sum and the programmed window length.
	sample_t     window_store [MAX_WINDOW];
	int unsigned next_slot;
	longint      window_total;
	cfg_t        window_len_reg;

	input_beat_t   pending_beats [$];
	average_beat_t expected_averages [$];

	int unsigned queued_count     = 0;
	int unsigned accepted_count   = 0;
	int unsigned results_checked  = 0;
	int unsigned mismatch_count   = 0;
	int unsigned settings_written = 0;

	int unsigned tx_gap    = 0;
	int unsigned rx_gap    = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;

	logic        hold_request = 1'b0;
	logic        sink_held    = 1'b0;
	bit          hold_done    = 1'b0;
	int unsigned hold_left    = 0;

	int unsigned cycle_count = 0;

	input_beat_t   next_beat;
	average_beat_t seen_beat;

	function automatic void restart_window(cfg_t len);
		window_len_reg = len;
		foreach (window_store[i])
			window_store[i] = '0;
		next_slot    = 0;
		window_total = 0;
	endfunction

	// A programmed length of zero behaves as one; anything above the store size saturates.
	function automatic int unsigned live_length();
		if (window_len_reg == 0)
			return 1;
		if (window_len_reg > MAX_WINDOW)
			return MAX_WINDOW;
		return window_len_reg;
	endfunction

	function automatic void predict_average(input_beat_t beat);
		int unsigned   len;
		int unsigned   slot;
		longint        mean;
		average_beat_t res;
		len  = live_length();
		slot = next_slot;
		if (slot >= len)
			slot = 0;
		window_total       -= longint'(window_store[slot]);
		window_store[slot]  = beat.sample_value;
		window_total       += longint'(beat.sample_value);
		slot++;
		if (slot >= len)
			slot = 0;
		next_slot = slot;
		// Signed integer division truncates toward zero, as the filter must.
		mean                   = window_total / longint'(len);
		res.average_value      = sample_t'(mean[31:0]);
		res.time_stamp_out     = beat.time_stamp;
		expected_averages.push_back(res);
	endfunction

	function automatic void check_average(average_beat_t got);
		average_beat_t want;
		results_checked++;
		if (expected_averages.size() == 0) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("%t: result beat with nothing expected: average %0d, stamp %h",
					$realtime, got.average_value, got.time_stamp_out);
			mismatch_count++;
			return;
		end
		want = expected_averages.pop_front();
		if (got.average_value !== want.average_value ||
				got.time_stamp_out !== want.time_stamp_out) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("%t: result %0d wrong: average %0d (expected %0d), stamp %h (expected %h)",
					$realtime, results_checked, got.average_value, want.average_value,
					got.time_stamp_out, want.time_stamp_out);
			mismatch_count++;
		end
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	function automatic sample_t pick_sample(sample_mix_t mix);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_HIGH: begin
				if (r < 80)
					return SAMPLE_MAX - sample_t'($urandom_range(0, 3));
			end
			MIX_LOW: begin
				if (r < 80)
					return SAMPLE_MIN + sample_t'($urandom_range(0, 3));
			end
			default: ;
		endcase
		r = $urandom_range(0, 99);
		if (r < 45)
			return sample_t'($urandom);
		if (r < 65)
			return sample_t'(int'($urandom_range(0, 200)) - 100);
		if (r < 75)
			return SAMPLE_MAX;
		if (r < 85)
			return SAMPLE_MIN;
		return sample_t'(int'($urandom_range(0, 2)) - 1);
	endfunction

	function automatic ts_t pick_stamp();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return ts_t'($urandom);
	endfunction

	function automatic void queue_beat(sample_t value, ts_t stamp);
		input_beat_t beat;
		beat.sample_value = value;
		beat.time_stamp   = stamp;
		pending_beats.push_back(beat);
		queued_count++;
	endfunction

	// The block is idle once every queued beat has been taken and every result has come back.
	// The counters move together with the queues inside one call, so no edge can split them.
	task automatic wait_for_drain();
		do
			@(posedge clk);
		while (accepted_count != queued_count || expected_averages.size() != 0);
	endtask

	// Called at a rising edge with the block idle; the shadow state restarts when the beat lands.
	task automatic write_window_len(cfg_t len);
		cfg_ch.window_len <= len;
		cfg_ch.valid      <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid      <= 1'b0;
		cfg_ch.window_len <= cfg_t'($urandom);
		restart_window(len);
		settings_written++;
	endtask

	task automatic run_phase(cfg_t len, int beats, sample_mix_t mix);
		wait_for_drain();
		repeat ($urandom_range(0, 5))
			@(posedge clk);
		write_window_len(len);
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		repeat (beats)
			queue_beat(pick_sample(mix), pick_stamp());
	endtask

	// Input driver: takes the next pending beat once the current one has been accepted and
	// any gap has run out. The shadow filter steps exactly at the accepting edge.
	always @(posedge clk) begin
		bit offering;
		if (arst_n) begin
			offering = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				next_beat.sample_value = in_ch.sample_value;
				next_beat.time_stamp   = in_ch.time_stamp;
				predict_average(next_beat);
				accepted_count++;
				offering = 1'b0;
			end
			if (!offering) begin
				if (tx_gap != 0) begin
					tx_gap--;
				end else if (pending_beats.size() != 0) begin
					next_beat = pending_beats.pop_front();
					offering  = 1'b1;
					tx_gap    = tx_steady ? 0 : pick_gap();
				end
			end
			// Idle cycles carry junk so that a payload sampled without valid shows up.
			if (offering && !(in_ch.valid && !(in_ch.valid && in_ch.ready))) begin
				in_ch.sample_value <= next_beat.sample_value;
				in_ch.time_stamp   <= next_beat.time_stamp;
			end else if (!offering) begin
				in_ch.sample_value <= sample_t'($urandom);
				in_ch.time_stamp   <= ts_t'($urandom);
			end
			in_ch.valid <= offering;
		end
	end

	// Result monitor: checks every accepted result beat and stalls the output at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				seen_beat.average_value  = out_ch.average_value;
				seen_beat.time_stamp_out = out_ch.time_stamp_out;
				check_average(seen_beat);
			end
			if (sink_held) begin
				out_ch.ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				rx_gap = rx_steady ? 0 : pick_gap();
			end
		end
	end

	// One long hold-off of the result side, counted here, so that the filter fills up and
	// refuses input while the driver keeps offering beats.
	always @(posedge clk) begin
		if (hold_request && hold_left == 0 && !hold_done) begin
			hold_left = HOLD_CYCLES;
			sink_held <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			if (hold_left == 0) begin
				sink_held <= 1'b0;
				hold_done = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, expected_averages.size());
			$display("** moving_average_filter: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.sample_value = '0;
		in_ch.time_stamp  = '0;
		out_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.window_len = '0;
		restart_window(maf_pkg::WINDOW_LEN_RESET);
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset window of four: the sum climbs to its positive and negative extremes,
		// then small values check truncation toward zero of negative sums.
		queue_beat(SAMPLE_MAX, 32'h0000_0000);
		queue_beat(SAMPLE_MAX, 32'hFFFF_FFFF);
		queue_beat(SAMPLE_MAX, 32'hAAAA_AAAA);
		queue_beat(SAMPLE_MAX, 32'h5555_5555);
		repeat (4)
			queue_beat(SAMPLE_MIN, 32'h0000_0001);
		queue_beat(sample_t'(0), 32'h8000_0000);
		queue_beat(sample_t'(-1), 32'h7FFF_FFFF);
		queue_beat(sample_t'(1), 32'h1234_5678);
		queue_beat(sample_t'(-3), 32'hFFFF_FFFE);
		queue_beat(sample_t'(2), 32'h0000_0002);

		// A length of zero must behave as a single-sample window.
		wait_for_drain();
		write_window_len(cfg_t'(0));
		queue_beat(SAMPLE_MIN, 32'hDEAD_BEEF);
		queue_beat(SAMPLE_MAX, 32'h0F0F_0F0F);
		queue_beat(sample_t'(-7), 32'hF0F0_F0F0);

		// All register bits set: the length saturates at the store size.
		wait_for_drain();
		write_window_len(cfg_t'(2047));
		repeat (3)
			queue_beat(SAMPLE_MIN, pick_stamp());
		queue_beat(sample_t'(-5), pick_stamp());

		wait_for_drain();
		write_window_len(cfg_t'(1));
		queue_beat(sample_t'(5), pick_stamp());
		queue_beat(sample_t'(-5), pick_stamp());

		// Random sequences over a spread of window settings, extremes included.
		run_phase(cfg_t'(0), 40, MIX_ANY);
		run_phase(cfg_t'(1), 40, MIX_ANY);
		run_phase(cfg_t'(2), 40, MIX_HIGH);
		run_phase(cfg_t'(3), 60, MIX_ANY);
		run_phase(cfg_t'(7), 60, MIX_LOW);
		run_phase(cfg_t'(16), 80, MIX_ANY);
		run_phase(cfg_t'(2047), 60, MIX_LOW);
		run_phase(cfg_t'(1025), 40, MIX_HIGH);
		run_phase(cfg_t'(1024), 60, MIX_ANY);
		// The long window wraps once; the result side is held off meanwhile.
		run_phase(cfg_t'(200), 260, MIX_ANY);
		hold_request <= 1'b1;
		repeat (5)
			run_phase(cfg_t'($urandom_range(1, 64)), 60, sample_mix_t'($urandom_range(0, 2)));
		run_phase(cfg_t'($urandom), 40, MIX_ANY);

		wait_for_drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (expected_averages.size() != 0)
			$display("%0d expected results never arrived.", expected_averages.size());
		$display("Covered %0d input beats and %0d result beats over %0d window settings.",
			accepted_count, results_checked, settings_written);
		$display("%0d result beats were wrong or unexpected.", mismatch_count);
		if (mismatch_count == 0 && expected_averages.size() == 0)
			$display("** moving_average_filter: PASSED **");
		else
			$display("** moving_average_filter: FAILED **");
		$finish;
	end

endmodule

// ----- moving_average_filter.f -----
+incdir+hdl
hdl/maf_pkg.sv
hdl/maf_if.sv
hdl/maf_ram.sv
hdl/maf_div.sv
hdl/moving_average_filter.sv
hdl/maf_checker.sv
bench/tb_moving_average_filter.sv
